[rtl/tsmp_pkg.sv]
`default_nettype none
package tsmp_pkg;

   localparam int UW         = 20;   // coordinate width
   localparam int FRAC       = 16;   // coordinate fraction bits
   localparam int CSR_IW     = 2;
   localparam int CSR_DW     = 11;

   localparam logic [CSR_IW-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_ADDR   = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_FILTER = 2'd3;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;
   localparam logic ADDR_CLAMP  = 1'b0;
   localparam logic ADDR_WRAP   = 1'b1;
   localparam logic FILT_POINT  = 1'b0;
   localparam logic FILT_BILIN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_COORD,
      ST_WRAP,
      ST_BASE,
      ST_FETCH,
      ST_BLEND,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

[rtl/tsmp_mod.sv]
`default_nettype none
// Restoring remainder unit: one quotient bit per cycle, result is the true modulo.
module tsmp_mod
   import tsmp_pkg::*;
#(
   parameter int CW = 18,
   parameter int DW = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [CW-1:0] coord,
   input  wire logic [DW-1:0]        modulus,
   output logic                      done,
   output logic [DW-1:0]             result
);

   localparam int NW = $clog2(CW + 1);

   logic [CW-1:0] mag_ff, mag_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff, mag_ff[CW-1]};
      if (start) begin
         neg_in  = coord[CW-1];
         mag_in  = coord[CW-1] ? CW'(-coord) : CW'(coord);
         rem_in  = '0;
         cnt_in  = NW'(CW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[CW-2:0], 1'b0};
         if (shifted >= {1'b0, modulus}) begin
            rem_in = DW'(shifted - {1'b0, modulus});
         end else begin
            rem_in = DW'(shifted);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done   = done_ff;
   assign result = (neg_ff && rem_ff != '0) ? DW'(modulus - rem_ff) : rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("modulo restarted while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < modulus) else $error("remainder not below modulus");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("done without a run");

endmodule
`default_nettype wire

[rtl/tsmp_ram.sv]
`default_nettype none
module tsmp_ram
   import tsmp_pkg::*;
#(
   parameter int AW = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] addr,
   input  wire logic [23:0]   wdata,
   output logic [23:0]        rdata
);

   logic [23:0] mem [0:(1<<AW)-1];
   logic [23:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/texture_sampler.sv]
`default_nettype none
// Texture sampler with a single-port RGB8 texel memory. A write word stores one
// texel in the cycle it is accepted. A sample word passes through the multiply,
// coordinate, base, fetch and output states, plus a blend state in bilinear
// mode and, in wrap mode, a wrap state for the serial remainder units (one bit
// a cycle). The four bilinear taps come one per cycle from the single memory
// port. MAX_TEXELS must be a power of two; texel addresses wrap modulo it.
// Never-written entries read as arbitrary data.
module texture_sampler
   import tsmp_pkg::*;
#(
   parameter int MAX_TEXELS = 65536,
   parameter int MAX_DIM    = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // texel_index[15:0], texel_red[23:16], texel_green[31:24], texel_blue[39:32],
   // u[59:40], v[79:60]
   input  wire logic [79:0]       req_tdata,
   // operation[0]
   input  wire logic              req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // red[15:0], green[31:16], blue[47:32]
   output logic [47:0]            rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_TEXELS);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int PW = UW + DW + 1;
   localparam int CW = PW + 1 - FRAC;
   localparam int LW = (AW > 2*DW + 1) ? AW : 2*DW + 1;

   // configuration
   logic [CSR_DW-1:0] width_ff, height_ff;
   logic              amode_ff, fmode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DW'(256);
         height_ff <= CSR_DW'(256);
         amode_ff  <= ADDR_CLAMP;
         fmode_ff  <= FILT_POINT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_ADDR:   amode_ff  <= csr_wdata[0];
            CSR_FILTER: fmode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] w_eff, h_eff;
   always_comb begin
      if (width_ff == '0) w_eff = DW'(1);
      else if (int'(width_ff) > MAX_DIM) w_eff = DW'(MAX_DIM);
      else w_eff = DW'(width_ff);
      if (height_ff == '0) h_eff = DW'(1);
      else if (int'(height_ff) > MAX_DIM) h_eff = DW'(MAX_DIM);
      else h_eff = DW'(height_ff);
   end

   // datapath registers
   state_type              state_ff, state_in;
   logic signed [UW-1:0]   u_ff, v_ff;
   logic signed [PW-1:0]   su_ff, sv_ff;
   logic [7:0]             dx_ff, dy_ff;
   logic [DW-1:0]          i0_ff, i1_ff, j0_ff, j1_ff;
   logic [2*DW-1:0]        row0_ff, row1_ff;
   logic [2:0]             k_ff;
   logic [23:0]            tap_ff [0:3];
   logic [15:0]            a_ff [0:2];
   logic [15:0]            b_ff [0:2];
   logic                   rsp_valid_ff;
   logic [47:0]            rsp_data_ff;

   // coordinate mapping
   logic signed [CW-1:0] cx, cy;

   function automatic logic signed [CW-1:0] map_coord(input logic signed [PW-1:0] s,
                                                      input logic bilin);
      logic signed [PW:0] se;
      logic signed [PW:0] t;
      begin
         se = {s[PW-1], s};
         if (bilin) begin
            t = se >>> FRAC;
         end else if (!s[PW-1]) begin
            t = (se + (PW+1)'(32768)) >>> FRAC;
         end else begin
            t = -(((-se) + (PW+1)'(32768)) >>> FRAC);
         end
         map_coord = CW'(t);
      end
   endfunction

   function automatic logic [DW-1:0] clamp(input logic signed [CW-1:0] c,
                                           input logic [DW-1:0] n);
      begin
         if (c[CW-1]) clamp = '0;
         else if (c > $signed(CW'({1'b0, n}) - CW'(1))) clamp = DW'(n - 1'b1);
         else clamp = DW'(c);
      end
   endfunction

   assign cx = map_coord(su_ff, fmode_ff);
   assign cy = map_coord(sv_ff, fmode_ff);

   // wrap units
   logic          mod_start, mod_done_x, mod_done_y;
   logic [DW-1:0] mx, my;

   assign mod_start = (state_ff == ST_COORD) && (amode_ff == ADDR_WRAP);

   tsmp_mod #(.CW(CW), .DW(DW)) u_mod_x (
      .clock(clock), .reset(reset), .start(mod_start), .coord(cx),
      .modulus(w_eff), .done(mod_done_x), .result(mx));

   tsmp_mod #(.CW(CW), .DW(DW)) u_mod_y (
      .clock(clock), .reset(reset), .start(mod_start), .coord(cy),
      .modulus(h_eff), .done(mod_done_y), .result(my));

   // texel memory
   logic          req_acc, mem_we;
   logic [AW-1:0] mem_addr;
   logic [23:0]   mem_rdata;
   logic [DW-1:0] i_sel;
   logic [2*DW-1:0] row_sel;
   logic [LW-1:0] tap_addr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign mem_we     = req_acc && (req_tuser == OP_WRITE);

   always_comb begin
      i_sel    = k_ff[0] ? i1_ff : i0_ff;
      row_sel  = k_ff[1] ? row1_ff : row0_ff;
      tap_addr = LW'(i_sel) + LW'(row_sel);
      if (state_ff == ST_IDLE) mem_addr = AW'(req_tdata[15:0]);
      else mem_addr = tap_addr[AW-1:0];
   end

   // A stored texel holds red in the top byte and blue in the bottom byte.
   tsmp_ram #(.AW(AW)) u_ram (
      .clock(clock), .we(mem_we), .addr(mem_addr),
      .wdata({req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]}),
      .rdata(mem_rdata));

   // control
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && req_tuser == OP_SAMPLE) state_in = ST_MUL;
         ST_MUL:   state_in = ST_COORD;
         ST_COORD: state_in = (amode_ff == ADDR_WRAP) ? ST_WRAP : ST_BASE;
         ST_WRAP:  if (mod_done_x) state_in = ST_BASE;
         ST_BASE:  state_in = ST_FETCH;
         ST_FETCH: begin
            if (fmode_ff == FILT_POINT && k_ff == 3'd1) state_in = ST_OUT;
            else if (k_ff == 3'd4) state_in = ST_BLEND;
         end
         ST_BLEND: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FETCH) k_ff <= k_ff + 3'd1;
         else k_ff <= '0;
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         u_ff <= req_tdata[59:40];
         v_ff <= req_tdata[79:60];
      end
      if (state_ff == ST_MUL) begin
         su_ff <= PW'($signed(u_ff) * $signed({1'b0, w_eff})) - PW'(32768);
         sv_ff <= PW'($signed(v_ff) * $signed({1'b0, h_eff})) - PW'(32768);
      end
      if (state_ff == ST_COORD) begin
         dx_ff <= su_ff[FRAC-1:FRAC-8];
         dy_ff <= sv_ff[FRAC-1:FRAC-8];
         i0_ff <= clamp(cx, w_eff);
         i1_ff <= clamp(cx + CW'(1), w_eff);
         j0_ff <= clamp(cy, h_eff);
         j1_ff <= clamp(cy + CW'(1), h_eff);
      end
      if (state_ff == ST_WRAP && mod_done_x) begin
         // The right and lower neighbours of the last column or row wrap to zero.
         i0_ff <= mx;
         i1_ff <= (mx == DW'(w_eff - 1'b1)) ? '0 : DW'(mx + 1'b1);
         j0_ff <= my;
         j1_ff <= (my == DW'(h_eff - 1'b1)) ? '0 : DW'(my + 1'b1);
      end
      if (state_ff == ST_BASE) begin
         row0_ff <= w_eff * j0_ff;
         row1_ff <= w_eff * j1_ff;
      end
      if (state_ff == ST_FETCH && k_ff != 3'd0) begin
         tap_ff[k_ff[1:0] - 2'd1] <= mem_rdata;
      end
      if (state_ff == ST_BLEND) begin
         for (int c = 0; c < 3; c++) begin
            a_ff[c] <= 16'(tap_ff[0][16-8*c +: 8] * (9'd256 - dx_ff))
                     + 16'(tap_ff[1][16-8*c +: 8] * dx_ff);
            b_ff[c] <= 16'(tap_ff[2][16-8*c +: 8] * (9'd256 - dx_ff))
                     + 16'(tap_ff[3][16-8*c +: 8] * dx_ff);
         end
      end
      if (state_ff == ST_OUT && out_free) begin
         for (int c = 0; c < 3; c++) begin
            if (fmode_ff == FILT_POINT) begin
               rsp_data_ff[16*c +: 16] <= {tap_ff[0][16-8*c +: 8], 8'd0};
            end else begin
               rsp_data_ff[16*c +: 16] <= 16'((25'(a_ff[c]) * (9'd256 - dy_ff)
                                    + 25'(b_ff[c]) * dy_ff + 25'd128) >> 8);
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_we_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_IDLE) else $error("texel write outside idle");
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT)) else $error("stray result");
   a_mod_pair: assert property (@(posedge clock) disable iff (reset)
      mod_done_x == mod_done_y) else $error("wrap units out of step");
   a_fetch_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> k_ff <= 3'd4) else $error("tap counter overrun");

endmodule
`default_nettype wire

[tb/sv/tb_texture_sampler.sv]
module tb_texture_sampler;
   timeunit 1ns;
   timeprecision 1ps;
   import tsmp_pkg::*;

   typedef struct {
      logic              op;
      logic [15:0]       index;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic signed [19:0] u;
      logic signed [19:0] v;
   } texel_req_type;

   localparam int STORE_DEPTH = 65536;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [79:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [47:0]       rsp_tdata;
   logic              csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = CSR_WIDTH;
   logic [CSR_DW-1:0] csr_wdata = '0;

   texture_sampler u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the block's state and registers
   logic [23:0]  texels [STORE_DEPTH];
   bit           filled [STORE_DEPTH];
   logic [10:0]  img_w = 11'd256;
   logic [10:0]  img_h = 11'd256;
   logic         addr_mode = ADDR_CLAMP;
   logic         filt_mode = FILT_POINT;

   texel_req_type pending_words [$];
   texel_req_type cur_word;
   logic [47:0]  expected_colours [$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           errors = 0;
   int           samples_seen = 0;
   int           writes_sent = 0;
   int           cycles = 0;

   function automatic longint eff_dim(logic [10:0] d);
      if (d == 0) return 1;
      if (d > 1024) return 1024;
      return longint'(d);
   endfunction

   function automatic longint fix_coord(longint c, longint n);
      longint m;
      if (addr_mode == ADDR_WRAP) begin
         m = c % n;
         if (m < 0) m += n;
         return m;
      end
      if (c < 0) return 0;
      if (c > n - 1) return n - 1;
      return c;
   endfunction

   function automatic logic [23:0] texel_at(longint x, longint y, longint w, longint h);
      longint a;
      a = fix_coord(x, w) + w * fix_coord(y, h);
      return texels[a[15:0]];
   endfunction

   function automatic logic [47:0] filter_colour(logic signed [19:0] u, logic signed [19:0] v);
      longint w, h, su, sv, x, y;
      int unsigned dx, dy, a, b, r;
      logic [23:0] t00, t10, t01, t11;
      logic [47:0] res;
      w = eff_dim(img_w);
      h = eff_dim(img_h);
      su = longint'(u) * w - 32768;
      sv = longint'(v) * h - 32768;
      if (filt_mode == FILT_POINT) begin
         x = (su >= 0) ? (su + 32768) / 65536 : -((-su + 32768) / 65536);
         y = (sv >= 0) ? (sv + 32768) / 65536 : -((-sv + 32768) / 65536);
         t00 = texel_at(x, y, w, h);
         return {t00[7:0], 8'd0, t00[15:8], 8'd0, t00[23:16], 8'd0};
      end
      x = su >>> 16;
      y = sv >>> 16;
      dx = int'((su - x * 65536) >> 8) & 255;
      dy = int'((sv - y * 65536) >> 8) & 255;
      t00 = texel_at(x, y, w, h);
      t10 = texel_at(x + 1, y, w, h);
      t01 = texel_at(x, y + 1, w, h);
      t11 = texel_at(x + 1, y + 1, w, h);
      for (int k = 0; k < 3; k++) begin
         a = t00[23-8*k -: 8] * (256 - dx) + t10[23-8*k -: 8] * dx;
         b = t01[23-8*k -: 8] * (256 - dx) + t11[23-8*k -: 8] * dx;
         r = (a * (256 - dy) + b * dy + 128) >> 8;
         res[16*k +: 16] = r[15:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
      errors++;
   endtask

   // Driver: a word leaves the queue only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            if (cur_word.op == OP_WRITE) begin
               texels[cur_word.index] = {cur_word.red, cur_word.green, cur_word.blue};
            end else begin
               expected_colours.push_back(filter_colour(cur_word.u, cur_word.v));
            end
         end
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= cur_word.op;
            req_tdata <= {cur_word.v, cur_word.u, cur_word.blue, cur_word.green,
                          cur_word.red, cur_word.index};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      logic [47:0] want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colours.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[15:0], 16'd0);
            end else begin
               want = expected_colours.pop_front();
               samples_seen++;
               if (rsp_tdata[15:0] !== want[15:0])
                  report_mismatch("red", rsp_tdata[15:0], want[15:0]);
               if (rsp_tdata[31:16] !== want[31:16])
                  report_mismatch("green", rsp_tdata[31:16], want[31:16]);
               if (rsp_tdata[47:32] !== want[47:32])
                  report_mismatch("blue", rsp_tdata[47:32], want[47:32]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WIDTH:  img_w = val;
         CSR_HEIGHT: img_h = val;
         CSR_ADDR:   addr_mode = val[0];
         CSR_FILTER: filt_mode = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_write(int idx, logic [23:0] rgb);
      texel_req_type t;
      t = '{OP_WRITE, idx[15:0], rgb[23:16], rgb[15:8], rgb[7:0],
            20'($urandom), 20'($urandom)};
      filled[idx[15:0]] = 1'b1;
      writes_sent++;
      pending_words.push_back(t);
   endtask

   task automatic push_sample(int u, int v);
      texel_req_type t;
      t = '{OP_SAMPLE, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            u[19:0], v[19:0]};
      pending_words.push_back(t);
   endtask

   // Waits until the block has nothing left to deliver, then sets a new shape.
   task automatic reconfigure(logic [10:0] w, logic [10:0] h, logic am, logic fm);
      longint span;
      do @(posedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_colours.size() != 0);
      repeat (SETTLE) @(posedge clock);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_ADDR, {10'd0, am});
      write_reg(CSR_FILTER, {10'd0, fm});
      // Every address that a sample can reach must hold a written texel. The
      // large directed shapes write the few texels that their samples touch.
      span = eff_dim(w) * eff_dim(h);
      if (span > 256) span = 0;
      for (int a = 0; a < span; a++)
         if (!filled[a]) push_write(a, 24'($urandom));
   endtask

   function automatic int near_coord();
      if ($urandom_range(4) == 0) return int'($urandom);
      return int'($urandom_range(5 * 65536)) - 2 * 65536;
   endfunction

   initial begin
      int span;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: small image, extremes of coordinates and texel bytes.
      reconfigure(11'd4, 11'd3, ADDR_CLAMP, FILT_POINT);
      push_write(65535, 24'hFFFFFF);
      push_write(0, 24'hFF00FF);
      push_write(5, 24'h00FF00);
      push_sample(-524288, -524288);
      push_sample(524287, 524287);
      push_sample(0, 0);
      push_sample(32768 / 4 * 3, 32768);
      push_sample(65536, 0);
      reconfigure(11'd4, 11'd3, ADDR_WRAP, FILT_BILIN);
      push_sample(-524288, 524287);
      push_sample(524287, -524288);
      push_sample(8192, 10923);
      push_sample(-65536 * 3 - 100, 0);
      push_sample(0, 0);
      // A zero width is used as one; a later shape uses an oversized height as the maximum.
      reconfigure(11'd0, 11'd5, ADDR_WRAP, FILT_BILIN);
      push_sample(12345, -99999);
      push_sample(-524288, 524287);
      reconfigure(11'd1024, 11'd1, ADDR_CLAMP, FILT_BILIN);
      push_write(515, 24'($urandom));
      push_write(516, 24'($urandom));
      push_write(1023, 24'($urandom));
      push_sample(33000, 40000);
      push_sample(524287, -524288);
      reconfigure(11'd1, 11'd2047, ADDR_WRAP, FILT_POINT);
      push_sample(-70000, 65535);
      push_sample(20, -524288);

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) begin
            send_idle_pct = 18; recv_idle_pct = 63;
         end else if (ph == 4) begin
            send_idle_pct = 63; recv_idle_pct = 18;
         end else if (ph == 8) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         reconfigure(11'($urandom_range(1, 16)), 11'($urandom_range(1, 16)),
                     1'($urandom), 1'($urandom));
         span = int'(eff_dim(img_w) * eff_dim(img_h));
         for (int n = 0; n < 25; n++) begin
            case ($urandom_range(9))
               0: push_write(int'($urandom_range(65535)), 24'($urandom));
               1, 2: push_write(int'($urandom_range(span - 1)), 24'($urandom));
               default: push_sample(near_coord(), near_coord());
            endcase
         end
      end

      do @(posedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_colours.size() != 0);
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d texel writes and %0d filtered samples over clamp, wrap,",
               writes_sent, samples_seen);
      $display("point and bilinear modes with image sizes from 1 to 1024 texels.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[texture_sampler.f]
rtl/tsmp_pkg.sv
rtl/tsmp_mod.sv
rtl/tsmp_ram.sv
rtl/texture_sampler.sv
tb/sv/tb_texture_sampler.sv
